// ===== hdl/irr_pkg.sv =====
`default_nettype none
package irr_pkg;

  localparam int HEADER_WORDS_DEF  = 11;
  localparam int TABLE_ENTRIES_DEF = 2;
  localparam int WORD_BYTES        = 8;
  localparam int QUEUE_DEPTH       = 2;
  localparam int NB_W              = 4;
  localparam int COUNT_W           = 31;
  localparam int CMP_W             = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] MODE_DECIDING = 2'd0;
  localparam logic [1:0] MODE_REPLY    = 2'd1;
  localparam logic [1:0] MODE_PASS     = 2'd2;

  localparam logic [7:0] PROTO_ICMP     = 8'd1;
  localparam logic [7:0] ICMP_ECHO_REQ  = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REP  = 8'd0;
  localparam logic [7:0] TTL_RESET      = 8'd125;
  localparam logic [6:0] ETH_HDR_BYTES  = 7'd14;
  localparam logic [6:0] ICMP_HDR_BYTES = 7'd8;
  localparam logic [CMP_W-1:0] MIN_FRAME_BYTES = 8'd34;
  localparam logic [CMP_W-1:0] IHL_BYTE_SEEN   = 8'd15;

  typedef struct packed {
    logic [63:0]     word;
    logic [NB_W-1:0] nb;
    logic            last;
  } q_item_t;

endpackage
`default_nettype wire

// ===== hdl/icmp_echo_reply_rewriter_unit.sv =====
// ICMP echo reply rewriter.
// in_*  : frame words (tdata = word[63:0], byte count[67:64]; tlast ends frame).
// cfg_* : write of reply_ttl (cfg_data), always ready; write only while idle.
// out_* : words (tdata = word[63:0], byte count[67:64], source count[98:68];
//         tuser = 1 for an echo reply; tlast ends frame).
// Header words are held until the frame can be classified (at most
// HEADER_WORDS words). Each held word is popped from the queue, then checked;
// a qualifying frame then passes through the rewrite sequencer
// (MAC swap, source table, IP checksum, ICMP type, ICMP checksum), and the
// held words leave one per cycle while out_tready is high. Words after the
// decision are registered in the 2-entry input queue and then in the output
// register, and stream at one word per cycle while out_tready is high.
// Reset clears the source table, the frame state and sets reply_ttl to 125.
// When the receiver stalls, the output register holds, the queue fills and
// in_tready drops; no item is lost.
`default_nettype none
module icmp_echo_reply_rewriter_unit #(
  parameter int HEADER_WORDS  = irr_pkg::HEADER_WORDS_DEF,
  parameter int TABLE_ENTRIES = irr_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,   // in_word, in_bytes, zero pad
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // out_word, out_bytes, source_count, zero pad
  output logic              out_tlast,
  output logic [0:0]        out_tuser,  // verdict
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data    // reply_ttl
);
  import irr_pkg::*;

  logic [7:0] ttl_r;
  logic       q_valid, q_pop;
  q_item_t    q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_valid) begin
      ttl_r <= cfg_data;
    end
  end

  irr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  irr_back #(
    .HEADER_WORDS  (HEADER_WORDS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .reply_ttl  (ttl_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== hdl/irr_front.sv =====
`default_nettype none
module irr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [71:0]     in_tdata,
  input  wire logic            in_tlast,
  output logic                 q_valid,
  output irr_pkg::q_item_t     q_item,
  input  wire logic            q_pop
);
  import irr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;
  logic [NB_W-1:0]    nb_raw;
  q_item_t            cls;

  // byte count is honored on the last word only; 0 or above 8 means full word
  always_comb begin
    nb_raw    = in_tdata[67:64];
    cls.word  = in_tdata[63:0];
    cls.last  = in_tlast;
    cls.nb    = nb_raw;
    if (!in_tlast || nb_raw == '0 || nb_raw > NB_W'(WORD_BYTES)) begin
      cls.nb = NB_W'(WORD_BYTES);
    end
  end

  assign in_tready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/irr_back.sv =====
`default_nettype none
module irr_back #(
  parameter int HEADER_WORDS  = irr_pkg::HEADER_WORDS_DEF,
  parameter int TABLE_ENTRIES = irr_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire irr_pkg::q_item_t q_item,
  output logic                 q_pop,
  input  wire logic [7:0]      reply_ttl,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [103:0]         out_tdata,
  output logic                 out_tlast,
  output logic [0:0]           out_tuser
);
  import irr_pkg::*;

  localparam int IDX_W  = $clog2(HEADER_WORDS);
  localparam int FILL_W = $clog2(HEADER_WORDS + 1);
  localparam int BP_W   = $clog2(HEADER_WORDS * WORD_BYTES + 1);
  localparam int TE_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_MAC     = 3'd2;
  localparam logic [2:0] ST_TABLE   = 3'd3;
  localparam logic [2:0] ST_IPSUM   = 3'd4;
  localparam logic [2:0] ST_ICMP_A  = 3'd5;
  localparam logic [2:0] ST_ICMP_B  = 3'd6;
  localparam logic [2:0] ST_FLUSH   = 3'd7;

  localparam logic [20:0] IP_ONES   = 21'(9 * 32'hffff);
  localparam logic [20:0] ICMP_ONES = 21'(3 * 32'hffff);

  function automatic logic [7:0] get_byte(input logic [63:0] w, input logic [2:0] b);
    return w[{3'd7 - b, 3'b000} +: 8];
  endfunction

  function automatic logic [63:0] set_byte(input logic [63:0] w, input logic [2:0] b,
                                           input logic [7:0] v);
    logic [63:0] r;
    r = w;
    r[{3'd7 - b, 3'b000} +: 8] = v;
    return r;
  endfunction

  function automatic logic [15:0] get16(input logic [63:0] w, input logic [1:0] s);
    return w[{2'd3 - s, 4'b0000} +: 16];
  endfunction

  function automatic logic [63:0] set16(input logic [63:0] w, input logic [1:0] s,
                                        input logic [15:0] v);
    logic [63:0] r;
    r = w;
    r[{2'd3 - s, 4'b0000} +: 16] = v;
    return r;
  endfunction

  function automatic logic [15:0] fold_csum(input logic [20:0] s);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = 17'(s[20:16]) + 17'(s[15:0]);
    s2 = s1[15:0] + 16'(s1[16]);
    return ~s2;
  endfunction

  logic [63:0]        store_r [HEADER_WORDS];
  logic [2:0]         state_r, state_nxt;
  logic [1:0]         mode_r;
  logic [FILL_W-1:0]  fill_r, k_r;
  logic [BP_W-1:0]    bp_r;
  logic               last_seen_r;
  logic [NB_W-1:0]    nb_dec_r;
  logic [6:0]         off_r;
  logic [15:0]        icmp_a_r;
  logic [31:0]        key_r;
  logic [TABLE_ENTRIES-1:0] match_r;
  logic [31:0]        keys_r   [TABLE_ENTRIES];
  logic [COUNT_W-1:0] counts_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [COUNT_W-1:0] fc_r;

  logic               out_valid_r, out_last_r, out_verdict_r;
  logic [63:0]        out_word_r;
  logic [NB_W-1:0]    out_nb_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               ld_ok, pop_dec, pop_str;
  logic [3:0]         ihl;
  logic [6:0]         off_c, off_end, off2;
  logic [CMP_W-1:0]   bp8, need;
  logic               decide, ok;
  logic               fin;
  logic               hit, any_free;
  logic [TE_W-1:0]    hidx, fidx;
  logic [15:0]        ip_old22, ip_new22, ip_csum, icmp_c, icmp_csum;
  logic [63:0]        w_off, w_off2;

  assign ld_ok   = !out_valid_r || out_tready;
  assign pop_dec = (state_r == ST_COLLECT) && q_valid && (mode_r == MODE_DECIDING);
  assign pop_str = (state_r == ST_COLLECT) && q_valid && (mode_r != MODE_DECIDING) && ld_ok;
  assign q_pop   = pop_dec || pop_str;

  always_comb begin
    ihl     = store_r[1][11:8];
    off_c   = ETH_HDR_BYTES + {1'b0, ihl, 2'b00};
    off_end = off_c + ICMP_HDR_BYTES;
    bp8     = CMP_W'(bp_r);
    need    = MIN_FRAME_BYTES;
    if (bp8 >= IHL_BYTE_SEEN && CMP_W'(off_end) > MIN_FRAME_BYTES) begin
      need = CMP_W'(off_end);
    end
    decide = (bp8 >= need) || last_seen_r || (fill_r == FILL_W'(HEADER_WORDS));
    ok = (bp8 >= MIN_FRAME_BYTES) && (store_r[2][7:0] == PROTO_ICMP) &&
         (bp8 >= CMP_W'(off_end)) &&
         (get_byte(store_r[IDX_W'(off_c[6:3])], off_c[2:0]) == ICMP_ECHO_REQ);
  end

  assign off2   = off_r + 7'd2;
  assign w_off  = store_r[IDX_W'(off_r[6:3])];
  assign w_off2 = store_r[IDX_W'(off2[6:3])];
  assign fin    = (k_r + 1'b1 == fill_r);

  // IP header: checksum updated incrementally for the TTL/protocol word
  always_comb begin
    ip_old22  = store_r[2][15:0];
    ip_new22  = {reply_ttl, store_r[2][7:0]};
    ip_csum   = fold_csum({5'b0, ~store_r[3][63:48]} + {5'b0, ~ip_old22} +
                          21'(ip_new22) + IP_ONES);
    icmp_c    = get16(w_off2, off2[2:1]);
    icmp_csum = fold_csum({5'b0, ~icmp_c} + {5'b0, ~icmp_a_r} +
                          21'({8'h00, icmp_a_r[7:0]}) + ICMP_ONES);
  end

  always_comb begin
    hit      = |match_r;
    any_free = ~&valid_r;
    hidx     = '0;
    fidx     = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hidx = TE_W'(i);
      if (!valid_r[i]) fidx = TE_W'(i);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (pop_dec) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!decide) state_nxt = ST_COLLECT;
        else if (ok) state_nxt = ST_MAC;
        else state_nxt = ST_FLUSH;
      end
      ST_MAC:    state_nxt = ST_TABLE;
      ST_TABLE:  state_nxt = ST_IPSUM;
      ST_IPSUM:  state_nxt = ST_ICMP_A;
      ST_ICMP_A: state_nxt = ST_ICMP_B;
      ST_ICMP_B: state_nxt = ST_FLUSH;
      ST_FLUSH:  if (ld_ok && fin) state_nxt = ST_COLLECT;
      default:   state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      mode_r      <= MODE_DECIDING;
      fill_r      <= '0;
      bp_r        <= '0;
      k_r         <= '0;
      last_seen_r <= 1'b0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop_str || (state_r == ST_FLUSH && ld_ok)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_COLLECT: begin
          if (pop_dec) begin
            fill_r      <= fill_r + 1'b1;
            bp_r        <= bp_r + BP_W'(q_item.nb);
            last_seen_r <= q_item.last;
          end
          if (pop_str) begin
            if (q_item.last) begin
              mode_r <= MODE_DECIDING;
              fc_r   <= '0;
            end
          end
        end
        ST_CHECK: begin
          k_r  <= '0;
          fc_r <= '0;
          if (decide) mode_r <= ok ? MODE_REPLY : MODE_PASS;
        end
        ST_TABLE: begin
          if (hit) fc_r <= (counts_r[hidx] < COUNT_MAX) ? counts_r[hidx] + 1'b1 : counts_r[hidx];
          else if (any_free) fc_r <= COUNT_W'(1);
          else fc_r <= '0;
        end
        ST_FLUSH: begin
          if (ld_ok) begin
            k_r <= k_r + 1'b1;
            if (fin) begin
              fill_r      <= '0;
              bp_r        <= '0;
              last_seen_r <= 1'b0;
              if (last_seen_r) mode_r <= MODE_DECIDING;
            end
          end
        end
        default: ;
      endcase
      if (state_r == ST_FLUSH && ld_ok && fin && last_seen_r) fc_r <= '0;
    end
  end

  // output payload and working registers
  always_ff @(posedge clk) begin
    if (pop_str) begin
      out_word_r    <= q_item.word;
      out_nb_r      <= q_item.nb;
      out_last_r    <= q_item.last;
      out_verdict_r <= (mode_r == MODE_REPLY);
      out_count_r   <= fc_r;
    end else if (state_r == ST_FLUSH && ld_ok) begin
      out_word_r    <= store_r[IDX_W'(k_r)];
      out_nb_r      <= fin ? nb_dec_r : NB_W'(WORD_BYTES);
      out_last_r    <= fin && last_seen_r;
      out_verdict_r <= (mode_r == MODE_REPLY);
      out_count_r   <= fc_r;
    end
    if (pop_dec) nb_dec_r <= q_item.nb;
    if (state_r == ST_CHECK) off_r <= off_c;
    if (state_r == ST_ICMP_A) icmp_a_r <= get16(w_off, off_r[2:1]);
    if (state_r == ST_MAC) begin
      key_r <= store_r[3][47:16];
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        match_r[i] <= valid_r[i] && (keys_r[i] == store_r[3][47:16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_COLLECT: if (pop_dec) store_r[IDX_W'(fill_r)] <= q_item.word;
      ST_MAC: begin
        store_r[0] <= {store_r[0][15:0], store_r[1][63:32], store_r[0][63:48]};
        store_r[1] <= {store_r[0][47:16], store_r[1][31:0]};
      end
      ST_TABLE: begin
        store_r[3] <= {store_r[3][63:48], store_r[3][15:0], store_r[4][63:48],
                       store_r[3][47:32]};
        store_r[4] <= {store_r[3][31:16], store_r[4][47:0]};
      end
      ST_IPSUM: begin
        store_r[2] <= {store_r[2][63:16], reply_ttl, store_r[2][7:0]};
        store_r[3] <= {ip_csum, store_r[3][47:0]};
      end
      ST_ICMP_A: store_r[IDX_W'(off_r[6:3])] <= set_byte(w_off, off_r[2:0], ICMP_ECHO_REP);
      ST_ICMP_B: store_r[IDX_W'(off2[6:3])] <= set16(w_off2, off2[2:1], icmp_csum);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) counts_r[i] <= '0;
    end else if (state_r == ST_TABLE) begin
      if (hit) begin
        if (counts_r[hidx] < COUNT_MAX) counts_r[hidx] <= counts_r[hidx] + 1'b1;
      end else if (any_free) begin
        valid_r[fidx]  <= 1'b1;
        counts_r[fidx] <= COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TABLE && !hit && any_free) keys_r[fidx] <= key_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_count_r, out_nb_r, out_word_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_verdict_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HEADER_WORDS)) else $error("header fill overrun");
  a_flush_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> (mode_r != MODE_DECIDING)) else $error("flush while deciding");
  a_pass_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_verdict_r) |-> (out_count_r == '0)) else $error("count on pass");
  a_rewrite_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |=> (mode_r == MODE_REPLY)) else $error("rewrite not reply");
`endif

endmodule
`default_nettype wire
